@@ rtl/p3lap_pkg.sv @@
// ----------------------------------------------------------------------------
// p3lap_pkg
// Shared types, sizes and codes for the periodic seven-point Laplacian block.
// ----------------------------------------------------------------------------
package p3lap_pkg;

	// grid geometry, each size a power of two so that a coordinate wraps by masking
	localparam int unsigned GRID_X = 16;
	localparam int unsigned GRID_Y = 16;
	localparam int unsigned GRID_Z = 16;
	localparam int unsigned FIELDS = 4;

	localparam int unsigned XW     = $clog2(GRID_X);
	localparam int unsigned YW     = $clog2(GRID_Y);
	localparam int unsigned ZW     = $clog2(GRID_Z);
	localparam int unsigned VOXELS = GRID_X * GRID_Y * GRID_Z;
	localparam int unsigned AW     = $clog2(VOXELS);

	// port widths
	localparam int unsigned CW  = 4;   // coordinate ports
	localparam int unsigned FW  = 24;  // Q7.16 field
	localparam int unsigned CFW = 16;  // Q8.8 coefficient
	localparam int unsigned LW  = 40;  // Q23.16 result
	localparam int unsigned MW  = FIELDS * FW;

	// datapath widths: second difference, product, three-term sum
	localparam int unsigned DW       = FW + 2;
	localparam int unsigned PW       = DW + CFW + 1;
	localparam int unsigned SW       = PW + 2;
	localparam int unsigned CFRAC    = 8;
	localparam int unsigned RND_HALF = 1 << (CFRAC - 1);

	// read sequence: centre, then minus and plus neighbour per axis
	localparam int unsigned READS = 7;
	localparam int unsigned STW   = $clog2(READS);

	// input mode codes
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_EVAL = 1'b1;

	// configuration register indexes
	localparam int unsigned         CFG_IW     = 2;
	localparam logic [CFG_IW-1:0]   CFG_COEF_X = 2'd0;
	localparam logic [CFG_IW-1:0]   CFG_COEF_Y = 2'd1;
	localparam logic [CFG_IW-1:0]   CFG_COEF_Z = 2'd2;
	localparam logic [CFW-1:0]      COEF_RESET = 16'd256;

	typedef enum logic [1:0] {
		SLOT_CTR,
		SLOT_MINUS,
		SLOT_PLUS
	} slot_t;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

	// controller to datapath
	typedef struct packed {
		logic  load;     // write the input voxel
		logic  capture;  // latch the evaluate coordinates
		logic  rd;       // read one stencil voxel
		slot_t slot;
		axis_t axis;
		logic  first;    // first product of an evaluation
		logic  last;     // last product of an evaluation
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic busy;      // a result is still in the pipeline
		logic out_hold;  // result register full and not taken this cycle
	} sts_t;

	// linear store address of a voxel
	function automatic logic [AW-1:0] cell_addr(logic [XW-1:0] x, logic [YW-1:0] y,
			logic [ZW-1:0] z);
		return AW'((int'(z) * GRID_Y + int'(y)) * GRID_X + int'(x));
	endfunction

endpackage

@@ rtl/p3lap_ram.sv @@
// ----------------------------------------------------------------------------
// p3lap_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module p3lap_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one access per cycle, write or read
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

@@ rtl/p3lap_ctrl.sv @@
// ----------------------------------------------------------------------------
// p3lap_ctrl
// Controller: input handshake and the seven-read sequence of an evaluation.
// ----------------------------------------------------------------------------
module p3lap_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              mode,
	input  p3lap_pkg::sts_t   sts,
	output logic              in_stall,
	output p3lap_pkg::cmd_t   cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_READ = 2'b10
	} state_t;

	state_t                       state_q;
	logic [p3lap_pkg::STW-1:0]    step_q;
	logic                         accept;

	// take items only when idle and the previous result can go out
	assign in_stall = (state_q != ST_IDLE) || sts.busy || sts.out_hold;
	assign accept   = in_valid && !in_stall;

	// command decode
	always_comb begin
		cmd.load    = accept && (mode == p3lap_pkg::MODE_LOAD);
		cmd.capture = accept && (mode == p3lap_pkg::MODE_EVAL);
		cmd.rd      = (state_q == ST_READ);
		cmd.first   = 1'b0;
		cmd.last    = 1'b0;
		cmd.slot    = p3lap_pkg::SLOT_CTR;
		cmd.axis    = p3lap_pkg::AXIS_X;
		unique case (step_q)
			3'd0: begin
				cmd.slot = p3lap_pkg::SLOT_CTR;
			end
			3'd1: begin
				cmd.slot = p3lap_pkg::SLOT_MINUS;
			end
			3'd2: begin
				cmd.slot  = p3lap_pkg::SLOT_PLUS;
				cmd.first = 1'b1;
			end
			3'd3: begin
				cmd.slot = p3lap_pkg::SLOT_MINUS;
				cmd.axis = p3lap_pkg::AXIS_Y;
			end
			3'd4: begin
				cmd.slot = p3lap_pkg::SLOT_PLUS;
				cmd.axis = p3lap_pkg::AXIS_Y;
			end
			3'd5: begin
				cmd.slot = p3lap_pkg::SLOT_MINUS;
				cmd.axis = p3lap_pkg::AXIS_Z;
			end
			3'd6: begin
				cmd.slot = p3lap_pkg::SLOT_PLUS;
				cmd.axis = p3lap_pkg::AXIS_Z;
				cmd.last = 1'b1;
			end
			default: begin
				cmd.slot = p3lap_pkg::SLOT_CTR;
			end
		endcase
	end

	// state and read step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.capture) begin
						state_q <= ST_READ;
						step_q  <= '0;
					end
				end
				ST_READ: begin
					if (step_q == p3lap_pkg::STW'(p3lap_pkg::READS - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/p3lap_dp.sv @@
// ----------------------------------------------------------------------------
// p3lap_dp
// Datapath: voxel store, coefficient registers, difference, multiply,
// accumulate and rounding stages, and the result register.
// ----------------------------------------------------------------------------
module p3lap_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  p3lap_pkg::cmd_t                       cmd,
	output p3lap_pkg::sts_t                       sts,
	input  logic                                  cfg_we,
	input  logic [p3lap_pkg::CFG_IW-1:0]          cfg_index,
	input  logic [p3lap_pkg::CFW-1:0]             cfg_data,
	input  logic [p3lap_pkg::CW-1:0]              pos_x,
	input  logic [p3lap_pkg::CW-1:0]              pos_y,
	input  logic [p3lap_pkg::CW-1:0]              pos_z,
	input  logic signed [p3lap_pkg::FW-1:0]       ld_field [p3lap_pkg::FIELDS],
	input  logic                                  out_stall,
	output logic                                  out_valid,
	output logic [p3lap_pkg::CW-1:0]              out_x,
	output logic [p3lap_pkg::CW-1:0]              out_y,
	output logic [p3lap_pkg::CW-1:0]              out_z,
	output logic signed [p3lap_pkg::LW-1:0]       lap [p3lap_pkg::FIELDS]
);

	localparam logic [p3lap_pkg::XW-1:0] X_LAST = p3lap_pkg::XW'(p3lap_pkg::GRID_X - 1);
	localparam logic [p3lap_pkg::YW-1:0] Y_LAST = p3lap_pkg::YW'(p3lap_pkg::GRID_Y - 1);
	localparam logic [p3lap_pkg::ZW-1:0] Z_LAST = p3lap_pkg::ZW'(p3lap_pkg::GRID_Z - 1);

	typedef struct packed {
		logic             valid;
		p3lap_pkg::slot_t slot;
		p3lap_pkg::axis_t axis;
		logic             first;
		logic             last;
	} tag_t;

	logic [p3lap_pkg::CFW-1:0]         coef_x_q, coef_y_q, coef_z_q;
	logic [p3lap_pkg::CFW-1:0]         coef_sel;
	logic [p3lap_pkg::XW-1:0]          x_q, nx;
	logic [p3lap_pkg::YW-1:0]          y_q, ny;
	logic [p3lap_pkg::ZW-1:0]          z_q, nz;
	logic [p3lap_pkg::AW-1:0]          ram_addr;
	logic [p3lap_pkg::MW-1:0]          ram_wdata, ram_rdata;
	tag_t                              tag_s1, tag_s2, tag_s3;
	logic                              last_s2, last_s3;
	logic                              first_s3;
	logic                              fin_s4;
	logic                              out_valid_q;
	logic signed [p3lap_pkg::FW-1:0]   rd_f     [p3lap_pkg::FIELDS];
	logic signed [p3lap_pkg::FW-1:0]   ctr_q    [p3lap_pkg::FIELDS];
	logic signed [p3lap_pkg::FW-1:0]   minus_q  [p3lap_pkg::FIELDS];
	logic signed [p3lap_pkg::DW-1:0]   diff_s2  [p3lap_pkg::FIELDS];
	logic signed [p3lap_pkg::PW-1:0]   prod_s3  [p3lap_pkg::FIELDS];
	logic signed [p3lap_pkg::SW-1:0]   total_q  [p3lap_pkg::FIELDS];
	logic signed [p3lap_pkg::SW-1:0]   rnd      [p3lap_pkg::FIELDS];
	logic signed [p3lap_pkg::LW-1:0]   lap_nx   [p3lap_pkg::FIELDS];
	logic signed [p3lap_pkg::LW-1:0]   lap_q    [p3lap_pkg::FIELDS];

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_x_q <= p3lap_pkg::COEF_RESET;
			coef_y_q <= p3lap_pkg::COEF_RESET;
			coef_z_q <= p3lap_pkg::COEF_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				p3lap_pkg::CFG_COEF_X: coef_x_q <= cfg_data;
				p3lap_pkg::CFG_COEF_Y: coef_y_q <= cfg_data;
				p3lap_pkg::CFG_COEF_Z: coef_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// evaluate coordinates, masking is the modulo for power-of-two grids
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q <= p3lap_pkg::XW'(pos_x);
			y_q <= p3lap_pkg::YW'(pos_y);
			z_q <= p3lap_pkg::ZW'(pos_z);
		end
	end

	// neighbour coordinate with periodic wrap
	always_comb begin
		nx = x_q;
		ny = y_q;
		nz = z_q;
		if (cmd.slot == p3lap_pkg::SLOT_MINUS) begin
			unique case (cmd.axis)
				p3lap_pkg::AXIS_X: nx = (x_q == '0) ? X_LAST : x_q - 1'b1;
				p3lap_pkg::AXIS_Y: ny = (y_q == '0) ? Y_LAST : y_q - 1'b1;
				p3lap_pkg::AXIS_Z: nz = (z_q == '0) ? Z_LAST : z_q - 1'b1;
				default: ;
			endcase
		end else if (cmd.slot == p3lap_pkg::SLOT_PLUS) begin
			unique case (cmd.axis)
				p3lap_pkg::AXIS_X: nx = (x_q == X_LAST) ? '0 : x_q + 1'b1;
				p3lap_pkg::AXIS_Y: ny = (y_q == Y_LAST) ? '0 : y_q + 1'b1;
				p3lap_pkg::AXIS_Z: nz = (z_q == Z_LAST) ? '0 : z_q + 1'b1;
				default: ;
			endcase
		end
	end

	// store address and write data
	always_comb begin
		if (cmd.load) begin
			ram_addr = p3lap_pkg::cell_addr(p3lap_pkg::XW'(pos_x), p3lap_pkg::YW'(pos_y),
				p3lap_pkg::ZW'(pos_z));
		end else begin
			ram_addr = p3lap_pkg::cell_addr(nx, ny, nz);
		end
		for (int f = 0; f < p3lap_pkg::FIELDS; f++) begin
			ram_wdata[f*p3lap_pkg::FW +: p3lap_pkg::FW] = ld_field[f];
			rd_f[f] = $signed(ram_rdata[f*p3lap_pkg::FW +: p3lap_pkg::FW]);
		end
	end

	p3lap_ram #(
		.WIDTH(p3lap_pkg::MW),
		.DEPTH(p3lap_pkg::VOXELS)
	) u_store (
		.clk  (clk),
		.en   (cmd.load || cmd.rd),
		.we   (cmd.load),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1      <= '0;
			tag_s2      <= '0;
			tag_s3      <= '0;
			fin_s4      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			tag_s1.valid <= cmd.rd;
			tag_s1.slot  <= cmd.slot;
			tag_s1.axis  <= cmd.axis;
			tag_s1.first <= cmd.first;
			tag_s1.last  <= cmd.last;
			tag_s2.valid <= tag_s1.valid && (tag_s1.slot == p3lap_pkg::SLOT_PLUS);
			tag_s2.slot  <= tag_s1.slot;
			tag_s2.axis  <= tag_s1.axis;
			tag_s2.first <= tag_s1.first;
			tag_s2.last  <= tag_s1.last;
			tag_s3       <= tag_s2;
			fin_s4       <= tag_s3.valid && tag_s3.last;
			priority if (fin_s4) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end else begin
				out_valid_q <= out_valid_q;
			end
		end
	end

	assign last_s2  = tag_s2.last;
	assign last_s3  = tag_s3.last;
	assign first_s3 = tag_s3.first;

	// coefficient of the axis in the multiply stage
	always_comb begin
		unique case (tag_s2.axis)
			p3lap_pkg::AXIS_X: coef_sel = coef_x_q;
			p3lap_pkg::AXIS_Y: coef_sel = coef_y_q;
			p3lap_pkg::AXIS_Z: coef_sel = coef_z_q;
			default:           coef_sel = coef_x_q;
		endcase
	end

	// rounding to Q.16, ties upward; 37 bits always fit the 40-bit result
	always_comb begin
		for (int f = 0; f < p3lap_pkg::FIELDS; f++) begin
			rnd[f]    = total_q[f] + p3lap_pkg::SW'(p3lap_pkg::RND_HALF);
			lap_nx[f] = p3lap_pkg::LW'($signed(rnd[f][p3lap_pkg::SW-1:p3lap_pkg::CFRAC]));
		end
	end

	// field arithmetic: capture centre and minus, second difference, multiply, accumulate
	always_ff @(posedge clk) begin
		for (int f = 0; f < p3lap_pkg::FIELDS; f++) begin
			if (tag_s1.valid && tag_s1.slot == p3lap_pkg::SLOT_CTR) begin
				ctr_q[f] <= rd_f[f];
			end
			if (tag_s1.valid && tag_s1.slot == p3lap_pkg::SLOT_MINUS) begin
				minus_q[f] <= rd_f[f];
			end
			diff_s2[f] <= p3lap_pkg::DW'(minus_q[f]) + p3lap_pkg::DW'(rd_f[f])
				- (p3lap_pkg::DW'(ctr_q[f]) <<< 1);
			prod_s3[f] <= p3lap_pkg::PW'(diff_s2[f])
				* p3lap_pkg::PW'($signed({1'b0, coef_sel}));
			if (tag_s3.valid) begin
				if (first_s3) begin
					total_q[f] <= p3lap_pkg::SW'(prod_s3[f]);
				end else begin
					total_q[f] <= total_q[f] + p3lap_pkg::SW'(prod_s3[f]);
				end
			end
			if (fin_s4) begin
				lap_q[f] <= lap_nx[f];
			end
		end
	end

	// status and result ports
	assign sts.busy     = tag_s1.valid || tag_s2.valid || tag_s3.valid || fin_s4
		|| (last_s2 && tag_s2.valid) || (last_s3 && tag_s3.valid);
	assign sts.out_hold = out_valid_q && out_stall;
	assign out_valid    = out_valid_q;
	assign out_x        = p3lap_pkg::CW'(x_q);
	assign out_y        = p3lap_pkg::CW'(y_q);
	assign out_z        = p3lap_pkg::CW'(z_q);
	assign lap          = lap_q;

endmodule

@@ rtl/periodic_3d_laplacian_stencil.sv @@
// ----------------------------------------------------------------------------
// periodic_3d_laplacian_stencil
// Seven-point Laplacian on a periodic 16x16x16 grid of four-field voxels.
//
//   channel  handshake            payload
//   in       in_valid/in_stall    mode, pos_x/y/z, field_0..3
//   out      out_valid/out_stall  out_x/y/z, lap_0..3
//   cfg      cfg_we               cfg_index, cfg_data
//
// A load writes the voxel in the transfer cycle.
// An evaluate makes seven reads of the single-port voxel store, then
// difference, multiply, accumulate and rounding.
// The voxel store has no reset; coefficients reset to 1.0.
// A held result blocks the input until it is taken.
// ----------------------------------------------------------------------------
module periodic_3d_laplacian_stencil (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [p3lap_pkg::CFG_IW-1:0]      cfg_index,
	input  logic [p3lap_pkg::CFW-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              mode,
	input  logic [p3lap_pkg::CW-1:0]          pos_x,
	input  logic [p3lap_pkg::CW-1:0]          pos_y,
	input  logic [p3lap_pkg::CW-1:0]          pos_z,
	input  logic signed [p3lap_pkg::FW-1:0]   field_0,
	input  logic signed [p3lap_pkg::FW-1:0]   field_1,
	input  logic signed [p3lap_pkg::FW-1:0]   field_2,
	input  logic signed [p3lap_pkg::FW-1:0]   field_3,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [p3lap_pkg::CW-1:0]          out_x,
	output logic [p3lap_pkg::CW-1:0]          out_y,
	output logic [p3lap_pkg::CW-1:0]          out_z,
	output logic signed [p3lap_pkg::LW-1:0]   lap_0,
	output logic signed [p3lap_pkg::LW-1:0]   lap_1,
	output logic signed [p3lap_pkg::LW-1:0]   lap_2,
	output logic signed [p3lap_pkg::LW-1:0]   lap_3
);

	p3lap_pkg::cmd_t                  cmd;
	p3lap_pkg::sts_t                  sts;
	logic signed [p3lap_pkg::FW-1:0]  ld_field [p3lap_pkg::FIELDS];
	logic signed [p3lap_pkg::LW-1:0]  lap      [p3lap_pkg::FIELDS];

	// gather and spread the field ports
	assign ld_field[0] = field_0;
	assign ld_field[1] = field_1;
	assign ld_field[2] = field_2;
	assign ld_field[3] = field_3;
	assign lap_0       = lap[0];
	assign lap_1       = lap[1];
	assign lap_2       = lap[2];
	assign lap_3       = lap[3];

	// controller
	p3lap_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.mode    (mode),
		.sts     (sts),
		.in_stall(in_stall),
		.cmd     (cmd)
	);

	// datapath
	p3lap_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z),
		.ld_field (ld_field),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_x    (out_x),
		.out_y    (out_y),
		.out_z    (out_z),
		.lap      (lap)
	);

endmodule

@@ rtl/p3lap_chk.sv @@
// ----------------------------------------------------------------------------
// p3lap_chk
// Port-level checks for the Laplacian block, bound to the top level.
// ----------------------------------------------------------------------------
module p3lap_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              mode,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [p3lap_pkg::CW-1:0]          out_x,
	input logic [p3lap_pkg::CW-1:0]          out_y,
	input logic [p3lap_pkg::CW-1:0]          out_z,
	input logic signed [p3lap_pkg::LW-1:0]   lap_0,
	input logic signed [p3lap_pkg::LW-1:0]   lap_1,
	input logic signed [p3lap_pkg::LW-1:0]   lap_2,
	input logic signed [p3lap_pkg::LW-1:0]   lap_3
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
			&& $stable(out_z) && $stable(lap_0) && $stable(lap_1)
			&& $stable(lap_2) && $stable(lap_3))
		else $error("stalled result changed");

	// an evaluate transfer starts the read sequence, the input closes
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && mode == p3lap_pkg::MODE_EVAL |=> in_stall && !out_valid)
		else $error("input open right after evaluate transfer");

	// a held result keeps the input closed
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while result held");

	// a load makes no result
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && mode == p3lap_pkg::MODE_LOAD && !out_valid |=> !out_valid)
		else $error("result after load transfer");

endmodule

bind periodic_3d_laplacian_stencil p3lap_chk u_p3lap_chk (.*);
